[hw/rtl/imu_srs_pkg.sv]
// Shared types and constants for the IMU SPI read sequencer.
package imu_srs_pkg;

  // Event kinds carried on the input side-band
  localparam logic [1:0] REQ_ACCEL_IRQ = 2'd0;
  localparam logic [1:0] REQ_GYRO_IRQ  = 2'd1;
  localparam logic [1:0] REQ_XFER_DONE = 2'd2;
  localparam logic [1:0] REQ_TASK_POLL = 2'd3;

  // Channel codes
  localparam logic [1:0] CH_GYRO  = 2'd0;
  localparam logic [1:0] CH_ACCEL = 2'd1;
  localparam logic [1:0] CH_TEMP  = 2'd2;
  localparam logic [1:0] CH_NONE  = 2'd0;

  // Transfer lengths in bytes
  localparam logic [3:0] LEN_GYRO  = 4'd8;
  localparam logic [3:0] LEN_ACCEL = 4'd9;
  localparam logic [3:0] LEN_TEMP  = 4'd4;
  localparam logic [3:0] LEN_NONE  = 4'd0;

  // Read command bytes
  localparam logic [7:0] CMD_GYRO  = 8'h82;
  localparam logic [7:0] CMD_ACCEL = 8'h92;
  localparam logic [7:0] CMD_TEMP  = 8'hA2;
  localparam logic [7:0] CMD_NONE  = 8'h00;

  // Flag bit positions
  localparam int F_READY  = 0;
  localparam int F_SPI    = 1;
  localparam int F_DONE   = 2;
  localparam int F_NOTIFY = 3;

  // Channel bookkeeping state
  typedef struct packed {
    logic [3:0] gyro_flags;
    logic [2:0] accel_flags;
    logic [2:0] temp_flags;
    logic       gyro_select;
    logic       accel_select;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    gyro_flags:   4'd0,
    accel_flags:  3'd0,
    temp_flags:   3'd0,
    gyro_select:  1'b1,
    accel_select: 1'b1
  };

  // One result per event
  typedef struct packed {
    logic       consume_temp;
    logic       consume_accel;
    logic       consume_gyro;
    logic       gyro_soft_irq;
    logic       cs_accel_level;
    logic       cs_gyro_level;
    logic [7:0] command_byte;
    logic [3:0] transfer_len;
    logic [1:0] start_channel;
    logic       start_valid;
  } seq_result_t;

endpackage

[hw/rtl/imu_srs_core.sv]
// Event decision logic: next channel state and result for one event.
module imu_srs_core (
  input  imu_srs_pkg::seq_state_t  state_i,
  input  logic [1:0]               req_type_i,
  input  logic                     dma_busy_i,
  input  logic                     reads_enabled_i,
  output imu_srs_pkg::seq_state_t  state_o,
  output imu_srs_pkg::seq_result_t result_o
);

  logic [3:0] g;
  logic [2:0] a;
  logic [2:0] t;
  logic       gs;
  logic       as_lvl;
  logic       try_en;
  imu_srs_pkg::seq_result_t res;

  always_comb begin
    g      = state_i.gyro_flags;
    a      = state_i.accel_flags;
    t      = state_i.temp_flags;
    gs     = state_i.gyro_select;
    as_lvl = state_i.accel_select;
    try_en = 1'b0;
    res    = '0;
    res.start_channel = imu_srs_pkg::CH_NONE;
    res.transfer_len  = imu_srs_pkg::LEN_NONE;
    res.command_byte  = imu_srs_pkg::CMD_NONE;

    // Event-specific flag updates ahead of the start attempt
    unique case (req_type_i)
      imu_srs_pkg::REQ_ACCEL_IRQ: begin
        a[imu_srs_pkg::F_READY] = 1'b1;
        t[imu_srs_pkg::F_READY] = 1'b1;
        try_en = reads_enabled_i;
      end
      imu_srs_pkg::REQ_GYRO_IRQ: begin
        g[imu_srs_pkg::F_READY] = 1'b1;
        try_en = reads_enabled_i;
      end
      imu_srs_pkg::REQ_XFER_DONE: begin
        if (g[imu_srs_pkg::F_SPI]) begin
          g[imu_srs_pkg::F_SPI]  = 1'b0;
          g[imu_srs_pkg::F_DONE] = 1'b1;
          gs = 1'b1;
        end
        if (a[imu_srs_pkg::F_SPI]) begin
          a[imu_srs_pkg::F_SPI]  = 1'b0;
          a[imu_srs_pkg::F_DONE] = 1'b1;
          as_lvl = 1'b1;
        end
        // temperature shares the accel chip select
        if (t[imu_srs_pkg::F_SPI]) begin
          t[imu_srs_pkg::F_SPI]  = 1'b0;
          t[imu_srs_pkg::F_DONE] = 1'b1;
          as_lvl = 1'b1;
        end
        try_en = 1'b1;
      end
      imu_srs_pkg::REQ_TASK_POLL: begin
        if (g[imu_srs_pkg::F_NOTIFY]) begin
          g[imu_srs_pkg::F_NOTIFY] = 1'b0;
          res.consume_gyro = 1'b1;
        end
        if (a[imu_srs_pkg::F_DONE]) begin
          a[imu_srs_pkg::F_DONE] = 1'b0;
          res.consume_accel = 1'b1;
        end
        if (t[imu_srs_pkg::F_DONE]) begin
          t[imu_srs_pkg::F_DONE] = 1'b0;
          res.consume_temp = 1'b1;
        end
      end
      default: ;
    endcase

    // Fixed-priority start: gyro, then accel, then temperature
    if (try_en && !dma_busy_i) begin
      priority if (g[imu_srs_pkg::F_READY] && !a[imu_srs_pkg::F_SPI] &&
                   !t[imu_srs_pkg::F_SPI]) begin
        g[imu_srs_pkg::F_READY] = 1'b0;
        g[imu_srs_pkg::F_SPI]   = 1'b1;
        gs = 1'b0;
        res.start_valid   = 1'b1;
        res.start_channel = imu_srs_pkg::CH_GYRO;
        res.transfer_len  = imu_srs_pkg::LEN_GYRO;
        res.command_byte  = imu_srs_pkg::CMD_GYRO;
      end else if (a[imu_srs_pkg::F_READY] && !g[imu_srs_pkg::F_SPI] &&
                   !t[imu_srs_pkg::F_SPI]) begin
        a[imu_srs_pkg::F_READY] = 1'b0;
        a[imu_srs_pkg::F_SPI]   = 1'b1;
        as_lvl = 1'b0;
        res.start_valid   = 1'b1;
        res.start_channel = imu_srs_pkg::CH_ACCEL;
        res.transfer_len  = imu_srs_pkg::LEN_ACCEL;
        res.command_byte  = imu_srs_pkg::CMD_ACCEL;
      end else if (t[imu_srs_pkg::F_READY] && !g[imu_srs_pkg::F_SPI] &&
                   !a[imu_srs_pkg::F_SPI]) begin
        t[imu_srs_pkg::F_READY] = 1'b0;
        t[imu_srs_pkg::F_SPI]   = 1'b1;
        as_lvl = 1'b0;
        res.start_valid   = 1'b1;
        res.start_channel = imu_srs_pkg::CH_TEMP;
        res.transfer_len  = imu_srs_pkg::LEN_TEMP;
        res.command_byte  = imu_srs_pkg::CMD_TEMP;
      end
    end

    // A finished gyro read turns into a notify on transfer complete
    if (req_type_i == imu_srs_pkg::REQ_XFER_DONE && g[imu_srs_pkg::F_DONE]) begin
      g[imu_srs_pkg::F_DONE]   = 1'b0;
      g[imu_srs_pkg::F_NOTIFY] = 1'b1;
      res.gyro_soft_irq = 1'b1;
    end

    res.cs_gyro_level  = gs;
    res.cs_accel_level = as_lvl;
  end

  assign state_o.gyro_flags   = g;
  assign state_o.accel_flags  = a;
  assign state_o.temp_flags   = t;
  assign state_o.gyro_select  = gs;
  assign state_o.accel_select = as_lvl;
  assign result_o             = res;

endmodule

[hw/rtl/imu_spi_read_sequencer_top.sv]
// Path: an accepted event sits in the input register, passes the decision logic and is
// then captured in the result register, which drives out_tvalid.
// Throughput: one event per cycle while results are taken without stalls.
// A stalled result holds one more event in the input register, then in_tready drops.
// Reset (rst_n low, synchronous): all channel flags clear, both chip selects
// deasserted (high), reads_enabled cleared, both pipeline stages empty.
module imu_spi_read_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  // Event requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] dma_busy, [7:1] zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] start_valid, [2:1] start_channel,
                                  // [6:3] transfer_len, [14:7] command_byte,
                                  // [15] cs_gyro_level, [16] cs_accel_level,
                                  // [17] gyro_soft_irq, [18] consume_gyro,
                                  // [19] consume_accel, [20] consume_temp,
                                  // [23:21] zero
  // Configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // [0] reads_enabled
);

  logic                     s1_valid_r;
  logic [1:0]               s1_req_r;
  logic                     s1_busy_r;
  logic                     out_valid_r;
  imu_srs_pkg::seq_result_t out_res_r;
  imu_srs_pkg::seq_state_t  state_r;
  imu_srs_pkg::seq_state_t  state_nxt;
  imu_srs_pkg::seq_result_t res_nxt;
  logic                     reads_enabled_r;
  logic                     advance;
  logic                     in_fire;

  // Handshake control
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reads_enabled_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      reads_enabled_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r  <= in_tuser;
      s1_busy_r <= in_tdata[0];
    end
  end

  imu_srs_core u_core (
    .state_i         (state_r),
    .req_type_i      (s1_req_r),
    .dma_busy_i      (s1_busy_r),
    .reads_enabled_i (reads_enabled_r),
    .state_o         (state_nxt),
    .result_o        (res_nxt)
  );

  // Channel state commits as the event moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imu_srs_pkg::STATE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

endmodule
